// ===== hw/rtl/nmf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 3x3 neighbor median filter: sizes, register indexes,
// the command record passed from front to back, and the window column type.
// No dependencies.
package nmf_pkg;

    // Pixel and frame geometry
    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = HEIGHT_W;
    localparam int LINE_W     = 2 * PIX_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Median selection
    localparam int NB_COUNT    = 8;
    localparam int RANK_W      = $clog2(NB_COUNT);
    localparam int MEDIAN_RANK = NB_COUNT / 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // One classified transaction
    typedef struct packed {
        logic [PIX_W-1:0] pix;   // pixel to store, zero for flush
        logic [COL_W-1:0] col;   // input column, line memory address
        logic             gen;   // this transaction completes an output
        logic             top;   // output on first row
        logic             bot;   // output on last row
        logic             lft;   // output on first column
        logic             rgt;   // output on last column
        logic             fend;  // output is the last of the frame
    } t_cmd;

    // One column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

endpackage

// ===== hw/rtl/neighbor_median_filter_3x3.sv =====
`timescale 1ns / 1ps
// Path: a result passes the command queue, the read stage, the neighbor stage and
//   the output register; results lag the input stream by one row plus one pixel.
// Throughput: one input transaction per cycle while the queue is not full, set by
//   the line memory: one read and one write per transaction, on separate ports.
// Reset: synchronous, active low; clears positions and handshake state, width 1024,
//   height 1. The line memory is not cleared and needs no clearing pass.
module neighbor_median_filter_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nmf_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [nmf_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nmf_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                          o_frame_end
);
    import nmf_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic queue_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Classify transactions and track frame position
    nmf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_in    (i_pixel_in),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Decouple front and back
    nmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Window, median and output
    nmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== hw/rtl/nmf_front.sv =====
`timescale 1ns / 1ps
// Front of the median filter: configuration registers, input position
// tracking and per-transaction classification. Depends on nmf_pkg.
module nmf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nmf_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [nmf_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output nmf_pkg::t_cmd                 o_cmd
);
    import nmf_pkg::*;

    typedef enum logic [2:0] {
        PH_ROW0 = 3'b001,
        PH_ROW1 = 3'b010,
        PH_BODY = 3'b100
    } t_in_phase;

    t_in_phase         r_in_phase, n_in_phase;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [COL_W-1:0]  r_last_col, n_last_col;
    logic [ROW_W-1:0]  r_last_row, n_last_row;

    logic                accept;
    logic                gen;
    logic                fend;
    logic [WIDTH_W-1:0]  w_raw;
    logic [WIDTH_W-1:0]  w_less;
    logic [HEIGHT_W-1:0] h_raw;
    logic [HEIGHT_W-1:0] h_less;
    logic [COL_W-1:0]    cfg_last_col;
    logic [ROW_W-1:0]    cfg_last_row;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept;

    // Clamp written geometry to the supported range, keep it as last index
    always_comb begin
        w_raw  = i_cfg_wr_data[WIDTH_W-1:0];
        w_less = w_raw - WIDTH_W'(1);
        h_raw  = i_cfg_wr_data[HEIGHT_W-1:0];
        h_less = h_raw - HEIGHT_W'(1);
        if (w_raw == '0) begin
            cfg_last_col = '0;
        end else if (w_raw > WIDTH_W'(MAX_WIDTH)) begin
            cfg_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = w_less[COL_W-1:0];
        end
        if (h_raw == '0) begin
            cfg_last_row = '0;
        end else begin
            cfg_last_row = h_less;
        end
    end

    // Classify the transaction at the head of the input channel
    always_comb begin
        unique case (r_in_phase)
            PH_ROW0: gen = 1'b0;
            PH_ROW1: gen = (r_in_col != '0);
            PH_BODY: gen = 1'b1;
            default: gen = 1'b0;
        endcase
        fend         = (r_out_row == r_last_row) && (r_out_col == r_last_col);
        o_cmd.pix    = i_mode ? '0 : i_pixel_in;
        o_cmd.col    = r_in_col;
        o_cmd.gen    = gen;
        o_cmd.top    = (r_out_row == '0);
        o_cmd.bot    = (r_out_row == r_last_row);
        o_cmd.lft    = (r_out_col == '0);
        o_cmd.rgt    = (r_out_col == r_last_col);
        o_cmd.fend   = fend;
    end

    // Advance input and output positions, restart on frame end or config
    always_comb begin
        n_in_phase = r_in_phase;
        n_in_col   = r_in_col;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  n_last_col = cfg_last_col;
                CFG_FRAME_HEIGHT: n_last_row = cfg_last_row;
                default:          n_last_col = r_last_col;
            endcase
            n_in_phase = PH_ROW0;
            n_in_col   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
        end else if (accept) begin
            if (r_in_col == r_last_col) begin
                n_in_col = '0;
                unique case (r_in_phase)
                    PH_ROW0: n_in_phase = PH_ROW1;
                    PH_ROW1: n_in_phase = PH_BODY;
                    PH_BODY: n_in_phase = PH_BODY;
                    default: n_in_phase = PH_ROW0;
                endcase
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (gen) begin
                if (fend) begin
                    n_in_phase = PH_ROW0;
                    n_in_col   = '0;
                    n_out_col  = '0;
                    n_out_row  = '0;
                end else if (r_out_col == r_last_col) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_phase <= PH_ROW0;
            r_in_col   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_last_col <= COL_W'(MAX_WIDTH - 1);
            r_last_row <= '0;
        end else begin
            r_in_phase <= n_in_phase;
            r_in_col   <= n_in_col;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
        end
    end

endmodule

// ===== hw/rtl/nmf_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back of the median filter.
// Depends on nmf_pkg.
module nmf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nmf_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output nmf_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import nmf_pkg::*;

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Track pointers and fill level
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/nmf_back.sv =====
`timescale 1ns / 1ps
// Back of the median filter: line memory, 3x3 window, neighbor masking,
// rank-based upper median and the output register. Depends on nmf_pkg.
module nmf_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  nmf_pkg::t_cmd            i_q_cmd,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [nmf_pkg::PIX_W-1:0] o_pixel_out,
    output logic                     o_frame_end
);
    import nmf_pkg::*;

    // Line memory: low byte is the previous row, high byte two rows back
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];

    logic              r_a_valid, n_a_valid;
    t_cmd              r_a_cmd;
    logic [LINE_W-1:0] r_rd_data;
    t_column           r_col_far;
    t_column           r_col_near;
    logic              r_n_valid, n_n_valid;
    logic [PIX_W-1:0]  r_nb [NB_COUNT];
    logic              r_n_fend;
    logic              r_o_valid, n_o_valid;
    logic [PIX_W-1:0]  r_o_pixel;
    logic              r_o_fend;

    logic              o_free;
    logic              n_adv;
    logic              n_free;
    logic              a_leave;
    logic              q_pop;
    logic [LINE_W-1:0] wr_data;
    t_column           new_col;
    logic [PIX_W-1:0]  nb_next [NB_COUNT];
    logic [RANK_W-1:0] rank [NB_COUNT];
    logic [PIX_W-1:0]  median;

    // Handshake chain from the output back to the queue
    assign o_free  = !r_o_valid || i_out_ready;
    assign n_adv   = r_n_valid && o_free;
    assign n_free  = !r_n_valid || n_adv;
    assign a_leave = r_a_valid && (!r_a_cmd.gen || n_free);
    assign q_pop   = i_q_valid && (!r_a_valid || a_leave);
    assign o_q_pop = q_pop;

    always_comb begin
        n_a_valid = q_pop ? 1'b1 : (a_leave ? 1'b0 : r_a_valid);
        n_n_valid = (a_leave && r_a_cmd.gen) ? 1'b1 : (n_adv ? 1'b0 : r_n_valid);
        n_o_valid = n_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_n_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_n_valid <= n_n_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Shift the old previous row up and store the new pixel
    assign wr_data = {r_rd_data[PIX_W-1:0], r_a_cmd.pix};

    // Write on leaving the read stage, read on entering it; forward a same-column write
    always_ff @(posedge i_clk) begin
        if (a_leave) begin
            r_line_mem[r_a_cmd.col] <= wr_data;
        end
        if (q_pop) begin
            r_a_cmd <= i_q_cmd;
            if (a_leave && (r_a_cmd.col == i_q_cmd.col)) begin
                r_rd_data <= wr_data;
            end else begin
                r_rd_data <= r_line_mem[i_q_cmd.col];
            end
        end
    end

    // Form the new window column and the masked neighbors
    always_comb begin
        new_col.top = r_rd_data[LINE_W-1:PIX_W];
        new_col.mid = r_rd_data[PIX_W-1:0];
        new_col.bot = r_a_cmd.pix;
        nb_next[0] = (r_a_cmd.lft || r_a_cmd.top) ? '0 : r_col_far.top;
        nb_next[1] = r_a_cmd.top                  ? '0 : r_col_near.top;
        nb_next[2] = (r_a_cmd.rgt || r_a_cmd.top) ? '0 : new_col.top;
        nb_next[3] = r_a_cmd.lft                  ? '0 : r_col_far.mid;
        nb_next[4] = r_a_cmd.rgt                  ? '0 : new_col.mid;
        nb_next[5] = (r_a_cmd.lft || r_a_cmd.bot) ? '0 : r_col_far.bot;
        nb_next[6] = r_a_cmd.bot                  ? '0 : r_col_near.bot;
        nb_next[7] = (r_a_cmd.rgt || r_a_cmd.bot) ? '0 : new_col.bot;
    end

    // Advance the window and capture neighbors of a completed position
    always_ff @(posedge i_clk) begin
        if (a_leave) begin
            r_col_far  <= r_col_near;
            r_col_near <= new_col;
            if (r_a_cmd.gen) begin
                r_nb     <= nb_next;
                r_n_fend <= r_a_cmd.fend;
            end
        end
    end

    // Rank each neighbor, ties broken by position, and pick the upper median
    always_comb begin
        for (int i = 0; i < NB_COUNT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < NB_COUNT; j++) begin
                if ((j != i) && ((r_nb[j] < r_nb[i]) || ((r_nb[j] == r_nb[i]) && (j < i)))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        median = '0;
        for (int i = 0; i < NB_COUNT; i++) begin
            if (rank[i] == RANK_W'(MEDIAN_RANK)) begin
                median = median | r_nb[i];
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_o_pixel <= median;
            r_o_fend  <= r_n_fend;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_pixel_out = r_o_pixel;
    assign o_frame_end = r_o_fend;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 neighbor median filter: random pixel frames in,
// medians checked against an in-bench frame predictor, random stalls on both channels.
// Depends on nmf_pkg and neighbor_median_filter_3x3.
module tb;
    import nmf_pkg::*;

    localparam int          RING_DEPTH     = 2 * MAX_WIDTH + 4;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_ITEMS   = 950;
    localparam int          LONG_HOLD      = 400;
    localparam int          CFG_SPARE_W    = CFG_DATA_W - WIDTH_W;
    localparam logic        MODE_PIXEL     = 1'b0;
    localparam logic        MODE_FLUSH     = 1'b1;

    typedef struct {
        logic             mode;
        logic [PIX_W-1:0] pix;
    } t_pixel_txn;

    typedef struct {
        logic [PIX_W-1:0] median;
        logic             fend;
    } t_median;

    // DUT ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode        = 1'b0;
    logic [PIX_W-1:0]      i_pixel_in    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_frame_end;

    // Transactions waiting to be offered, and medians waiting to come out
    t_pixel_txn pending_px[$];
    t_median    median_q[$];

    // Predictor state
    logic [PIX_W-1:0]    line_hist [RING_DEPTH];
    logic [WIDTH_W-1:0]  width_reg  = 11'd1024;
    logic [HEIGHT_W-1:0] height_reg = 13'd1;
    int in_row, in_col, out_row, out_col;

    // Run statistics
    int mismatches    = 0;
    int pixels_taken  = 0;
    int medians_seen  = 0;
    int frames_seen   = 0;
    int reg_writes    = 0;
    int random_items  = 0;

    // Driver and receiver pacing
    int  drv_gap     = 0;
    int  drv_calm    = 0;
    int  drv_roll;
    int  hold_left   = 0;
    int  rdy_calm    = 0;
    int  rdy_roll;
    bit  long_hold_done = 1'b0;
    int  quiet_cycles = 0;

    neighbor_median_filter_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_in    (i_pixel_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_frame_end   (o_frame_end)
    );

    always #6 i_clk = ~i_clk;

    // Width 0 acts as 1, anything above the line size saturates
    function automatic int eff_width();
        if (width_reg == '0) return 1;
        if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    // Fifth smallest of eight
    function automatic logic [PIX_W-1:0] upper_median8(input logic [NB_COUNT-1:0][PIX_W-1:0] v);
        logic [PIX_W-1:0] s [NB_COUNT];
        logic [PIX_W-1:0] t;
        int i, j;
        for (i = 0; i < NB_COUNT; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && s[j-1] > t) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = t;
        end
        return s[MEDIAN_RANK];
    endfunction

    function automatic void restart_positions();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    // Advance the frame by one accepted transaction; queue the median it completes
    function automatic void filter_step(input logic mode, input logic [PIX_W-1:0] pix_in);
        int w, h, total, q, p, rr, cc, dr, dc, n;
        logic [PIX_W-1:0] px;
        logic [NB_COUNT-1:0][PIX_W-1:0] nb;
        t_median m;
        w     = eff_width();
        h     = eff_height();
        total = w * h;
        q     = in_row * w + in_col;
        px    = (mode == MODE_FLUSH || q >= total) ? '0 : pix_in;
        line_hist[q % RING_DEPTH] = px;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (q < w + 1) return;
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                    rr = out_row + dr;
                    cc = out_col + dc;
                    nb[n] = '0;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                        nb[n] = line_hist[(rr * w + cc) % RING_DEPTH];
                    n++;
                end
            end
        end
        p        = out_row * w + out_col;
        m.median = upper_median8(nb);
        m.fend   = (p + 1 >= total);
        if (m.fend) begin
            restart_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        median_q.push_back(m);
    endfunction

    // Driver: offer pending transactions, predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap    <= 0;
            drv_calm   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                filter_step(i_mode, i_pixel_in);
                pixels_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (drv_gap != 0) begin
                    drv_gap    <= drv_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_px.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_mode     <= pending_px[0].mode;
                    i_pixel_in <= pending_px[0].pix;
                    void'(pending_px.pop_front());
                    // pick the idle gap that follows this transaction
                    if (drv_calm != 0) begin
                        drv_calm <= drv_calm - 1;
                    end else begin
                        drv_roll = $urandom_range(0, 99);
                        if (drv_roll < 3)
                            drv_calm <= $urandom_range(30, 120);
                        else if (drv_roll < 55)
                            drv_gap <= 0;
                        else if (drv_roll < 85)
                            drv_gap <= $urandom_range(1, 3);
                        else if (drv_roll < 97)
                            drv_gap <= $urandom_range(4, 12);
                        else
                            drv_gap <= $urandom_range(20, 50);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each median transaction, pace the output ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
            rdy_calm    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                medians_seen++;
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected result pixel_out %0d frame_end %0b",
                             $time, o_pixel_out, o_frame_end);
                    mismatches++;
                end else begin
                    if (o_pixel_out !== median_q[0].median) begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, median_q[0].median, o_pixel_out);
                        mismatches++;
                    end
                    if (o_frame_end !== median_q[0].fend) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, median_q[0].fend, o_frame_end);
                        mismatches++;
                    end
                    if (median_q[0].fend) frames_seen++;
                    void'(median_q.pop_front());
                end
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && medians_seen >= 60) begin
                // back up the whole pipe once so the input has to stall
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                i_out_ready    <= 1'b0;
            end else if (rdy_calm != 0) begin
                rdy_calm    <= rdy_calm - 1;
                i_out_ready <= 1'b1;
            end else begin
                rdy_roll = $urandom_range(0, 99);
                if (rdy_roll < 3) begin
                    rdy_calm    <= $urandom_range(30, 120);
                    i_out_ready <= 1'b1;
                end else if (rdy_roll < 60) begin
                    i_out_ready <= 1'b1;
                end else if (rdy_roll < 92) begin
                    i_out_ready <= 1'b0;
                    hold_left   <= $urandom_range(0, 2);
                end else begin
                    i_out_ready <= 1'b0;
                    hold_left   <= $urandom_range(8, 40);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, median_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every transaction went in and every median came out, then let the pipe settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_px.size() != 0 || i_in_valid || median_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            width_reg = data[WIDTH_W-1:0];
        else
            height_reg = data[HEIGHT_W-1:0];
        restart_positions();
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w_data);
        write_reg(CFG_FRAME_HEIGHT, h_data);
    endtask

    task automatic push_px(input logic mode, input logic [PIX_W-1:0] pix);
        t_pixel_txn t;
        t.mode = mode;
        t.pix  = pix;
        pending_px.push_back(t);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Queue one frame: stop_at < 0 runs it to frame end, 0 cuts it at random, > 0 cuts there
    task automatic queue_frame(input int stop_at, output int queued);
        int w, total, len, k;
        logic mode;
        w     = eff_width();
        total = w * eff_height();
        len   = total + w + 1;
        if (stop_at == 0)
            len = $urandom_range(1, len - 1);
        else if (stop_at > 0 && stop_at < len)
            len = stop_at;
        for (k = 0; k < len; k++) begin
            if (k < total)
                mode = ($urandom_range(0, 99) < 8) ? MODE_FLUSH : MODE_PIXEL;
            else
                mode = ($urandom_range(0, 99) < 25) ? MODE_PIXEL : MODE_FLUSH;
            push_px(mode, rand_pixel());
        end
        queued = len;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 65) return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 92) return CFG_DATA_W'($urandom_range(7, 24));
        return CFG_DATA_W'($urandom_range(25, 64));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 70) return CFG_DATA_W'($urandom_range(1, 6));
        return CFG_DATA_W'($urandom_range(7, 30));
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] w_new, h_new;
        int sel, nfr, f, queued, wr_eff, hr_eff;
        bit first;

        foreach (line_hist[i]) line_hist[i] = '0;
        restart_positions();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry is 1024 wide: a handful of pixels completes nothing
        repeat (5) push_px(MODE_PIXEL, rand_pixel());

        // 3x3 frame: extreme values, an early flush, a late pixel in the tail
        set_frame(13'd3, 13'd3);
        push_px(MODE_PIXEL, 8'h00);
        push_px(MODE_PIXEL, 8'hFF);
        push_px(MODE_PIXEL, 8'h55);
        push_px(MODE_PIXEL, 8'hAA);
        push_px(MODE_PIXEL, 8'hFF);
        push_px(MODE_FLUSH, 8'h3C);
        push_px(MODE_PIXEL, 8'h0F);
        push_px(MODE_PIXEL, 8'hF0);
        push_px(MODE_PIXEL, 8'h01);
        push_px(MODE_FLUSH, 8'h00);
        push_px(MODE_PIXEL, 8'h80);
        push_px(MODE_FLUSH, 8'hFF);
        push_px(MODE_FLUSH, 8'h00);

        // Zero width and height act as a single pixel; width upper bits are dropped
        set_frame(13'h1800, 13'd0);
        push_px(MODE_PIXEL, 8'd200);
        push_px(MODE_FLUSH, 8'd0);
        push_px(MODE_PIXEL, 8'd77);

        // 2x2 frame of all ones
        set_frame(13'd2, 13'd2);
        repeat (4) push_px(MODE_PIXEL, 8'hFF);
        push_px(MODE_FLUSH, 8'h00);
        push_px(MODE_PIXEL, 8'hFF);
        push_px(MODE_FLUSH, 8'h00);

        // Tallest frame, one pixel wide, cut short
        set_frame(13'd1, 13'h1FFF);
        queue_frame(120, queued);

        // Random geometries, a few frames each, some cut short by the next write
        first = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            w_new = pick_width();
            h_new = pick_height();
            sel   = first ? 0 : $urandom_range(0, 4);
            if (sel == 3) h_new = height_reg;
            if (sel == 4) w_new = CFG_DATA_W'(width_reg);
            wr_eff = (w_new[WIDTH_W-1:0] == '0) ? 1 : int'(w_new[WIDTH_W-1:0]);
            if (wr_eff > MAX_WIDTH) wr_eff = MAX_WIDTH;
            hr_eff = (h_new == '0) ? 1 : int'(h_new);
            if (wr_eff * hr_eff > 300) begin
                sel   = 0;
                h_new = CFG_DATA_W'(300 / wr_eff);
            end
            wait_drained();
            w_new[CFG_DATA_W-1:WIDTH_W] = CFG_SPARE_W'($urandom_range(0, 3));
            if (sel != 4) write_reg(CFG_FRAME_WIDTH, w_new);
            if (sel != 3) write_reg(CFG_FRAME_HEIGHT, h_new);
            first = 1'b0;
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++) begin
                queue_frame((f == nfr - 1 && $urandom_range(0, 99) < 15) ? 0 : -1, queued);
                random_items += queued;
            end
        end

        wait_drained();
        $display("covered %0d pixel transactions, %0d medians, %0d completed frames",
                 pixels_taken, medians_seen, frames_seen);
        $display("%0d register writes, %0d field mismatches", reg_writes, mismatches);
        if (mismatches == 0 && median_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
